### sv/chip8_fetch_execute_subset_core_assert.svh
// Assertion macros shared by the CHIP-8 fetch/execute core RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CHIP8_FETCH_EXECUTE_SUBSET_CORE_ASSERT_SVH
`define CHIP8_FETCH_EXECUTE_SUBSET_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define C8FE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define C8FE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/c8fe_pkg.sv
// Package for the CHIP-8 fetch/execute core: widths, opcode groups, types.
// Used by the interfaces and every module of the core; depends on nothing.
`default_nettype none

package c8fe_pkg;

  localparam int MEMORY_BYTES_DEFAULT = 4096;

  localparam int ADDR_W   = 12;
  localparam int BYTE_W   = 8;
  localparam int OPCODE_W = 16;
  localparam int REG_W    = 4;
  localparam int NUM_REGS = 16;

  localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;

  // Command encoding of an input word.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EXEC = 1'b1;

  // Opcode groups (top nibble) that the core executes.
  localparam logic [3:0] OP_JP  = 4'h1;
  localparam logic [3:0] OP_SE  = 4'h3;
  localparam logic [3:0] OP_LD  = 4'h6;
  localparam logic [3:0] OP_ADD = 4'h7;
  localparam logic [3:0] OP_LDI = 4'hA;
  localparam logic [3:0] OP_RND = 4'hC;

  typedef enum logic {
    BK_ISSUE,
    BK_EXEC
  } back_state_t;

  // Classified word as it sits in the queue between front and back.
  typedef struct packed {
    logic              is_exec;
    logic              in_range;
    logic [ADDR_W-1:0] load_address;
    logic [BYTE_W-1:0] load_data;
    logic [BYTE_W-1:0] random_byte;
  } c8fe_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   pc_after;
    logic [ADDR_W-1:0]   index_value;
    logic [OPCODE_W-1:0] fetched_opcode;
    logic                reg_written;
    logic [REG_W-1:0]    reg_number;
    logic [BYTE_W-1:0]   reg_value;
    logic                skipped;
    logic                unsupported;
  } c8fe_result_t;

endpackage

`default_nettype wire

### sv/c8fe_item_if.sv
// Input channel of the CHIP-8 core: valid/ready plus the command word fields.
// Depends on c8fe_pkg.
`default_nettype none

interface c8fe_item_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [c8fe_pkg::ADDR_W-1:0] load_address;
  logic [c8fe_pkg::BYTE_W-1:0] load_data;
  logic [c8fe_pkg::BYTE_W-1:0] random_byte;

  modport source (output valid, command, load_address, load_data, random_byte,
                  input ready);
  modport sink (input valid, command, load_address, load_data, random_byte,
                output ready);
endinterface

`default_nettype wire

### sv/c8fe_result_if.sv
// Output channel of the CHIP-8 core: valid/ready plus the result word fields.
// Depends on c8fe_pkg.
`default_nettype none

interface c8fe_result_if;
  logic                          valid;
  logic                          ready;
  logic [c8fe_pkg::ADDR_W-1:0]   pc_after;
  logic [c8fe_pkg::ADDR_W-1:0]   index_value;
  logic [c8fe_pkg::OPCODE_W-1:0] fetched_opcode;
  logic                          reg_written;
  logic [c8fe_pkg::REG_W-1:0]    reg_number;
  logic [c8fe_pkg::BYTE_W-1:0]   reg_value;
  logic                          skipped;
  logic                          unsupported;

  modport source (output valid, pc_after, index_value, fetched_opcode, reg_written,
                  reg_number, reg_value, skipped, unsupported,
                  input ready);
  modport sink (input valid, pc_after, index_value, fetched_opcode, reg_written,
                reg_number, reg_value, skipped, unsupported,
                output ready);
endinterface

`default_nettype wire

### sv/c8fe_front.sv
// Front end of the CHIP-8 core: accepts command words, classifies them and
// holds them in a two-entry queue for the back end. Depends on c8fe_pkg.
`default_nettype none

module c8fe_front #(
  parameter int MEMORY_BYTES = c8fe_pkg::MEMORY_BYTES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  c8fe_item_if.sink            item,
  output logic                 q_valid,
  output c8fe_pkg::c8fe_item_t q_head,
  input  logic                 q_pop
);

  localparam logic [c8fe_pkg::ADDR_W:0] MEM_LIMIT = (c8fe_pkg::ADDR_W + 1)'(MEMORY_BYTES);

  c8fe_pkg::c8fe_item_t entries [2];
  c8fe_pkg::c8fe_item_t classified;
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 push;

  // A load beyond the implemented memory is marked so the back end drops it.
  always_comb begin
    classified.is_exec      = (item.command == c8fe_pkg::CMD_EXEC);
    classified.in_range     = ({1'b0, item.load_address} < MEM_LIMIT);
    classified.load_address = item.load_address;
    classified.load_data    = item.load_data;
    classified.random_byte  = item.random_byte;
  end

  assign item.ready = (count != 2'd2);
  assign push       = item.valid && item.ready;
  assign q_valid    = (count != 2'd0);
  assign q_head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

endmodule

`default_nettype wire

### sv/c8fe_back.sv
// Back end of the CHIP-8 core: program memory, pc, I and V registers, the
// fetch/execute sequencer and the result register. Depends on c8fe_pkg.
`default_nettype none
`include "chip8_fetch_execute_subset_core_assert.svh"

module c8fe_back #(
  parameter int MEMORY_BYTES = c8fe_pkg::MEMORY_BYTES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  c8fe_pkg::c8fe_item_t q_head,
  output logic                 q_pop,
  c8fe_result_if.source        result
);

  localparam int AW = $clog2(MEMORY_BYTES);
  localparam logic [c8fe_pkg::ADDR_W:0] MEM_LIMIT = (c8fe_pkg::ADDR_W + 1)'(MEMORY_BYTES);

  c8fe_pkg::back_state_t state, state_next;

  logic [c8fe_pkg::BYTE_W-1:0] mem [MEMORY_BYTES];

  logic [c8fe_pkg::ADDR_W-1:0] pc;
  logic [c8fe_pkg::ADDR_W-1:0] pc_plus1;
  logic [c8fe_pkg::ADDR_W-1:0] index_reg;
  logic [c8fe_pkg::BYTE_W-1:0] vreg [c8fe_pkg::NUM_REGS];

  logic [c8fe_pkg::BYTE_W-1:0] rd_hi;
  logic [c8fe_pkg::BYTE_W-1:0] rd_lo;
  logic                        hi_ok;
  logic                        lo_ok;
  logic [c8fe_pkg::BYTE_W-1:0] rnd_byte;

  logic can_emit;
  logic mem_we;
  logic fetch_en;
  logic emit_load;
  logic emit_exec;
  logic emit;

  logic [c8fe_pkg::OPCODE_W-1:0] opcode;
  logic [c8fe_pkg::REG_W-1:0]    x;
  logic [c8fe_pkg::BYTE_W-1:0]   kk;
  logic [c8fe_pkg::ADDR_W-1:0]   nnn;
  logic [c8fe_pkg::BYTE_W-1:0]   vx;
  logic [c8fe_pkg::ADDR_W-1:0]   pc_next;
  logic [c8fe_pkg::ADDR_W-1:0]   index_next;
  logic                          wr;
  logic [c8fe_pkg::BYTE_W-1:0]   rval;
  logic                          skip;
  logic                          unsup;

  logic                   out_valid;
  c8fe_pkg::c8fe_result_t out_word;
  c8fe_pkg::c8fe_result_t out_next;

  assign can_emit = !out_valid || result.ready;
  assign emit     = emit_load || emit_exec;
  assign pc_plus1 = pc + 12'd1;

  // Sequencer: a load finishes in the issue state, an execute reads both
  // opcode bytes there and ends in the execute state, when output is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c8fe_pkg::BK_ISSUE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    fetch_en   = 1'b0;
    emit_load  = 1'b0;
    emit_exec  = 1'b0;
    unique case (state)
      c8fe_pkg::BK_ISSUE: begin
        if (q_valid) begin
          if (q_head.is_exec) begin
            q_pop      = 1'b1;
            fetch_en   = 1'b1;
            state_next = c8fe_pkg::BK_EXEC;
          end else if (can_emit) begin
            q_pop     = 1'b1;
            mem_we    = q_head.in_range;
            emit_load = 1'b1;
          end
        end
      end
      c8fe_pkg::BK_EXEC: begin
        if (can_emit) begin
          emit_exec  = 1'b1;
          state_next = c8fe_pkg::BK_ISSUE;
        end
      end
      default: begin
        state_next = c8fe_pkg::BK_ISSUE;
      end
    endcase
  end

  // Program memory: one write port, two registered read ports for the opcode.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_head.load_address[AW-1:0]] <= q_head.load_data;
    end
    if (fetch_en) begin
      rd_hi <= mem[pc[AW-1:0]];
      rd_lo <= mem[pc_plus1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_en) begin
      hi_ok    <= ({1'b0, pc} < MEM_LIMIT);
      lo_ok    <= ({1'b0, pc_plus1} < MEM_LIMIT);
      rnd_byte <= q_head.random_byte;
    end
  end

  // Instruction decode and execute.
  always_comb begin
    opcode     = {(hi_ok ? rd_hi : 8'h00), (lo_ok ? rd_lo : 8'h00)};
    x          = opcode[11:8];
    kk         = opcode[7:0];
    nnn        = opcode[11:0];
    vx         = vreg[x];
    pc_next    = pc + 12'd2;
    index_next = index_reg;
    wr         = 1'b0;
    rval       = 8'h00;
    skip       = 1'b0;
    unsup      = 1'b0;
    unique case (opcode[15:12])
      c8fe_pkg::OP_JP: begin
        pc_next = nnn;
      end
      c8fe_pkg::OP_SE: begin
        if (vx == kk) begin
          skip    = 1'b1;
          pc_next = pc + 12'd4;
        end
      end
      c8fe_pkg::OP_LD: begin
        wr   = 1'b1;
        rval = kk;
      end
      c8fe_pkg::OP_ADD: begin
        wr   = 1'b1;
        rval = vx + kk;
      end
      c8fe_pkg::OP_LDI: begin
        index_next = nnn;
      end
      c8fe_pkg::OP_RND: begin
        wr   = 1'b1;
        rval = rnd_byte & kk;
      end
      default: begin
        unsup = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= c8fe_pkg::PC_RESET;
      index_reg <= '0;
      vreg      <= '{default: '0};
    end else if (emit_exec) begin
      pc        <= pc_next;
      index_reg <= index_next;
      if (wr) begin
        vreg[x] <= rval;
      end
    end
  end

  // Result register; a load reports the current pc and I with all else zero.
  always_comb begin
    if (emit_exec) begin
      out_next.pc_after       = pc_next;
      out_next.index_value    = index_next;
      out_next.fetched_opcode = opcode;
      out_next.reg_written    = wr;
      out_next.reg_number     = wr ? x : 4'h0;
      out_next.reg_value      = rval;
      out_next.skipped        = skip;
      out_next.unsupported    = unsup;
    end else begin
      out_next.pc_after       = pc;
      out_next.index_value    = index_reg;
      out_next.fetched_opcode = '0;
      out_next.reg_written    = 1'b0;
      out_next.reg_number     = '0;
      out_next.reg_value      = '0;
      out_next.skipped        = 1'b0;
      out_next.unsupported    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word <= out_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.pc_after       = out_word.pc_after;
  assign result.index_value    = out_word.index_value;
  assign result.fetched_opcode = out_word.fetched_opcode;
  assign result.reg_written    = out_word.reg_written;
  assign result.reg_number     = out_word.reg_number;
  assign result.reg_value      = out_word.reg_value;
  assign result.skipped        = out_word.skipped;
  assign result.unsupported    = out_word.unsupported;

  `C8FE_ASSERT_IMPL(a_no_pop_in_exec, clk, rst, state == c8fe_pkg::BK_EXEC, !q_pop, "queue popped while an instruction is executing")
  `C8FE_ASSERT_NEXT(a_issue_keeps_pc, clk, rst, state == c8fe_pkg::BK_ISSUE, pc == $past(pc), "pc changed outside the execute step")
  `C8FE_ASSERT_NEXT(a_skip_adds_four, clk, rst, emit_exec && skip, pc == $past(pc) + 12'd4, "skip did not advance pc by four")
  `C8FE_ASSERT_IMPL(a_write_not_unsup, clk, rst, out_valid && out_word.reg_written, !out_word.unsupported, "register write reported on an unsupported opcode")

endmodule

`default_nettype wire

### sv/chip8_fetch_execute_subset_core.sv
// Throughput: one load per cycle while the result side takes every word; an execute
// keeps the back end from taking a new word until it is done, since the registered opcode
// fetch from program memory is followed by the execute step that produces the next pc.
// Reset (synchronous, active high): pc = 0x200, I and V0..VF cleared, queue and result
// register emptied. Program memory is not cleared and holds no valid bits.
`default_nettype none

module chip8_fetch_execute_subset_core #(
  parameter int MEMORY_BYTES = c8fe_pkg::MEMORY_BYTES_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  c8fe_item_if.sink     item,
  c8fe_result_if.source result
);

  // The front end accepts a word whenever its two-entry queue has room, so
  // input acceptance never waits on the result side directly. The back end
  // drains the queue in order: a load writes one memory byte and reports the
  // current pc and I, an execute fetches both opcode bytes together and
  // retires the instruction once the output register can take it. Results sit
  // in an output register that is refilled in the same cycle it is taken.

  logic                 q_valid;
  logic                 q_pop;
  c8fe_pkg::c8fe_item_t q_head;

  c8fe_front #(
    .MEMORY_BYTES(MEMORY_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  c8fe_back #(
    .MEMORY_BYTES(MEMORY_BYTES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop),
    .result (result)
  );

endmodule

`default_nettype wire

### tb/c8fe_shadow_core.sv
// Shadow interpreter for the CHIP-8 fetch/execute core: watches both channels,
// predicts each result word and compares it. Depends on c8fe_pkg and the channel interfaces.
`timescale 1ns / 100ps

module c8fe_shadow_core
  import c8fe_pkg::*;
#(
  parameter int MEMORY_BYTES = MEMORY_BYTES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  c8fe_item_if                             item,
  c8fe_result_if                           result,
  output int                               fail_count,
  output int                               outstanding,
  output logic [ADDR_W-1:0]                pc_now,
  output logic [NUM_REGS-1:0][BYTE_W-1:0]  vregs,
  output int                               exec_count,
  output int                               write_count,
  output int                               skip_count,
  output int                               unsup_count
);

  logic [BYTE_W-1:0] prog_mem [MEMORY_BYTES];
  logic [ADDR_W-1:0] index_q;
  c8fe_result_t      result_trace [$];

  function automatic logic [BYTE_W-1:0] fetch_byte(input logic [ADDR_W-1:0] a);
    if (int'(a) < MEMORY_BYTES) return prog_mem[a];
    return '0;
  endfunction

  // Applies one word to the shadow state and returns the result word it causes.
  function automatic c8fe_result_t interpret_word(input logic cmd,
                                                  input logic [ADDR_W-1:0] laddr,
                                                  input logic [BYTE_W-1:0] ldata,
                                                  input logic [BYTE_W-1:0] rnd);
    c8fe_result_t        r;
    logic [OPCODE_W-1:0] op;
    logic [ADDR_W-1:0]   next_pc;
    logic [REG_W-1:0]    x;
    logic [BYTE_W-1:0]   kk;
    r = '0;
    if (cmd == CMD_LOAD) begin
      if (int'(laddr) < MEMORY_BYTES) prog_mem[laddr] = ldata;
    end else begin
      op = {fetch_byte(pc_now), fetch_byte(pc_now + 12'd1)};
      x = op[11:8];
      kk = op[7:0];
      next_pc = pc_now + 12'd2;
      case (op[15:12])
        OP_JP: next_pc = op[11:0];
        OP_SE: begin
          if (vregs[x] == kk) begin
            r.skipped = 1'b1;
            next_pc = pc_now + 12'd4;
          end
        end
        OP_LD: begin
          r.reg_written = 1'b1;
          r.reg_value = kk;
        end
        OP_ADD: begin
          r.reg_written = 1'b1;
          r.reg_value = vregs[x] + kk;
        end
        OP_LDI: index_q = op[11:0];
        OP_RND: begin
          r.reg_written = 1'b1;
          r.reg_value = rnd & kk;
        end
        default: r.unsupported = 1'b1;
      endcase
      if (r.reg_written) begin
        vregs[x] = r.reg_value;
        r.reg_number = x;
      end
      r.fetched_opcode = op;
      pc_now = next_pc;
    end
    r.pc_after = pc_now;
    r.index_value = index_q;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : track
    c8fe_result_t due;
    c8fe_result_t fresh;
    if (rst) begin
      pc_now = PC_RESET;
      index_q = '0;
      vregs = '0;
      result_trace.delete();
      fail_count = 0;
      outstanding = 0;
      exec_count = 0;
      write_count = 0;
      skip_count = 0;
      unsup_count = 0;
    end else begin
      // A result always comes after its word is accepted, so check before predicting.
      if (result.valid && result.ready) begin
        if (result_trace.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, actual pc_after 0x%0h",
                   $time, result.pc_after);
          fail_count++;
        end else begin
          due = result_trace.pop_front();
          check_field("pc_after", 16'(due.pc_after), 16'(result.pc_after));
          check_field("index_value", 16'(due.index_value), 16'(result.index_value));
          check_field("fetched_opcode", due.fetched_opcode, result.fetched_opcode);
          check_field("reg_written", 16'(due.reg_written), 16'(result.reg_written));
          check_field("reg_number", 16'(due.reg_number), 16'(result.reg_number));
          check_field("reg_value", 16'(due.reg_value), 16'(result.reg_value));
          check_field("skipped", 16'(due.skipped), 16'(result.skipped));
          check_field("unsupported", 16'(due.unsupported), 16'(result.unsupported));
        end
      end
      if (item.valid && item.ready) begin
        fresh = interpret_word(item.command, item.load_address, item.load_data,
                               item.random_byte);
        if (item.command == CMD_EXEC) exec_count++;
        if (fresh.reg_written) write_count++;
        if (fresh.skipped) skip_count++;
        if (fresh.unsupported) unsup_count++;
        result_trace.push_back(fresh);
      end
      outstanding = result_trace.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the CHIP-8 fetch/execute core testbench: clock, reset and word stimulus.
// Depends on c8fe_pkg, the channel interfaces, the core and c8fe_shadow_core.
`timescale 1ns / 100ps

module testbench;
  import c8fe_pkg::*;

  localparam int MEM_BYTES = MEMORY_BYTES_DEFAULT;

  // Boot program, one {address, byte} pair per entry. In execution order it does:
  // LD V0,FF; ADD V0,01 (wraps to zero); SE V0,00 (skips 0x206); LD I,FFF;
  // RND VF,F0; a Dxyn draw (unsupported); JP FFF; then SE VF,00 fetched across
  // the top of memory (high byte at 0xFFF, low byte at 0x000), which does not skip.
  localparam logic [19:0] BOOT_IMAGE [16] = '{
    {12'h200, 8'h60}, {12'h201, 8'hFF}, {12'h202, 8'h70}, {12'h203, 8'h01},
    {12'h204, 8'h30}, {12'h205, 8'h00}, {12'h208, 8'hAF}, {12'h209, 8'hFF},
    {12'h20A, 8'hCF}, {12'h20B, 8'hF0}, {12'h20C, 8'hD1}, {12'h20D, 8'h23},
    {12'h20E, 8'h1F}, {12'h20F, 8'hFF}, {12'hFFF, 8'h3F}, {12'h000, 8'h00}
  };
  localparam int BOOT_STEPS = 8;

  logic clk;
  logic rst;

  c8fe_item_if   item_ch ();
  c8fe_result_if result_ch ();

  chip8_fetch_execute_subset_core #(
    .MEMORY_BYTES(MEM_BYTES)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  int                             shadow_failures;
  int                             shadow_outstanding;
  logic [ADDR_W-1:0]              shadow_pc;
  logic [NUM_REGS-1:0][BYTE_W-1:0] shadow_regs;
  int                             n_exec;
  int                             n_writes;
  int                             n_skips;
  int                             n_unsup;

  // The shadow interpreter sees exactly what the core sees on both channels.
  c8fe_shadow_core #(
    .MEMORY_BYTES(MEM_BYTES)
  ) shadow (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (shadow_failures),
    .outstanding(shadow_outstanding),
    .pc_now     (shadow_pc),
    .vregs      (shadow_regs),
    .exec_count (n_exec),
    .write_count(n_writes),
    .skip_count (n_skips),
    .unsup_count(n_unsup)
  );

  // Percent chance per cycle that the sender or the receiver holds back.
  int sender_idle = 0;
  int receiver_idle = 0;
  int words_sent = 0;

  // Bytes the stimulus has written. Program memory is undefined until written,
  // so an instruction is only executed once both of its bytes are loaded here.
  bit loaded [4096];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random; the rate follows the current phase.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= ($urandom_range(99) >= receiver_idle);
    end
  end

  // Called at a falling edge. Idles at random, presents one word, waits for the
  // handshake and returns at the next falling edge with valid still high, so a
  // back-to-back word never lowers valid in between.
  task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data, input logic [BYTE_W-1:0] rnd);
    while ($urandom_range(99) < sender_idle) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.command <= cmd;
    item_ch.load_address <= addr;
    item_ch.load_data <= data;
    item_ch.random_byte <= rnd;
    if (cmd == CMD_LOAD) loaded[addr] = 1'b1;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Holds the sender off until every word sent so far has produced its result.
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(negedge clk);
    while (shadow_outstanding != 0) @(negedge clk);
  endtask

  // Random program execution. Mostly instructions: when the bytes at the pc are
  // missing, or at random, a fresh instruction is written there first, so the
  // core runs real code with random content; jumps backward reuse old code.
  // The rest are stray loads anywhere in memory, which can also corrupt code.
  task automatic run_phase(input int send_pct, input int recv_pct, input int words);
    int                stop_at;
    int                sel;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] nnn;
    logic [REG_W-1:0]  x;
    logic [BYTE_W-1:0] kk;
    logic [OPCODE_W-1:0] op;
    sender_idle = send_pct;
    receiver_idle = recv_pct;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      // Decided at a falling edge, so the shadow pc and registers are current.
      pc = shadow_pc;
      if ($urandom_range(99) < 12) begin
        send_word(CMD_LOAD, ADDR_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      end else begin
        if (!loaded[pc] || !loaded[pc + 12'd1] || $urandom_range(99) < 40) begin
          x = REG_W'($urandom);
          kk = BYTE_W'($urandom);
          nnn = ADDR_W'($urandom);
          sel = $urandom_range(99);
          if (sel < 10) begin
            // Jumps go anywhere, close to the top of memory, or a few steps back.
            case ($urandom_range(2))
              1: nnn = 12'hFFC + ADDR_W'($urandom_range(3));
              2: nnn = pc - ADDR_W'(2 * $urandom_range(1, 8));
              default: ;
            endcase
            op = {OP_JP, nnn};
          end else if (sel < 28) begin
            // Compare against the live register half of the time so skips happen.
            if ($urandom_range(1) == 1) kk = shadow_regs[x];
            op = {OP_SE, x, kk};
          end else if (sel < 46) begin
            op = {OP_LD, x, kk};
          end else if (sel < 64) begin
            op = {OP_ADD, x, kk};
          end else if (sel < 74) begin
            op = {OP_LDI, nnn};
          end else if (sel < 88) begin
            op = {OP_RND, x, kk};
          end else begin
            op = {4'($urandom), nnn};
          end
          send_word(CMD_LOAD, pc, op[15:8], BYTE_W'($urandom));
          send_word(CMD_LOAD, pc + 12'd1, op[7:0], BYTE_W'($urandom));
        end
        send_word(CMD_EXEC, ADDR_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      end
    end
  endtask

  initial begin
    int i;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.command = CMD_LOAD;
    item_ch.load_address = '0;
    item_ch.load_data = '0;
    item_ch.random_byte = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed boot program. RND uses a fixed byte 0xA5, so VF ends up 0xA0 and
    // the final compare against 0x00 falls through.
    for (i = 0; i < 16; i++) begin
      send_word(CMD_LOAD, BOOT_IMAGE[i][19:8], BOOT_IMAGE[i][7:0], BYTE_W'($urandom));
    end
    for (i = 0; i < BOOT_STEPS; i++) begin
      send_word(CMD_EXEC, ADDR_W'($urandom), BYTE_W'($urandom), 8'hA5);
    end
    drain();

    // Slow receiver first, then slow sender, then full speed both ways.
    run_phase(37, 81, 310);
    drain();
    run_phase(81, 37, 310);
    drain();
    run_phase(0, 0, 310);
    drain();
    repeat (8) @(negedge clk);

    $display("Ran %0d words: %0d loads and %0d instructions.", words_sent,
             words_sent - n_exec, n_exec);
    $display("Instructions wrote a register %0d times, skipped %0d times, %0d unsupported.",
             n_writes, n_skips, n_unsup);
    if (shadow_failures == 0 && shadow_outstanding == 0) begin
      $display("chip8_fetch_execute_subset_core test passed");
    end else begin
      $display("chip8_fetch_execute_subset_core test failed");
    end
    $finish;
  end

  // Watchdog: a correct run takes a small fraction of this.
  initial begin
    #2000000;
    $display("chip8_fetch_execute_subset_core test failed");
    $finish;
  end

endmodule
